// ----- rtl/dds_header_size_checker_top_assert.svh -----
// Assertion macros for the texture header size checker.
// Used by dds_header_size_checker_top; expects clk and rst_n in scope.
`ifndef DDS_HEADER_SIZE_CHECKER_TOP_ASSERT_SVH
`define DDS_HEADER_SIZE_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define DHSC_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define DHSC_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/dhsc_pkg.sv -----
// Shared constants and types for the texture header size checker.
// No dependencies; used by dhsc_check and dds_header_size_checker_top.
`default_nettype none

package dhsc_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned DIM_W   = 21;
    localparam int unsigned LEN_W   = 42;
    localparam int unsigned FLOOR_W = 5;

    localparam logic [31:0] DESC_SIZE    = 32'd124;
    localparam logic [31:0] PF_SIZE      = 32'd32;
    localparam logic [31:0] HDR_BYTES    = 32'd128;
    localparam logic [31:0] FLG_REQUIRED = 32'h0000_1007;
    localparam logic [31:0] FLG_PITCH    = 32'h0000_0008;
    localparam logic [31:0] FLG_LINEAR   = 32'h0008_0000;
    localparam logic [31:0] FLG_DEPTH    = 32'h0080_0000;
    localparam logic [31:0] FLG_MIPS     = 32'h0002_0000;
    localparam logic [31:0] PF_FOURCC    = 32'h0000_0004;
    localparam logic [31:0] DIM_LIMIT    = 32'h0010_0000;
    localparam logic [31:0] CODE_DXT1    = 32'h3154_5844;
    localparam logic [23:0] CODE_DXT     = 24'h54_5844;

    localparam logic [FLOOR_W-1:0] FLOOR_DXT1  = 5'd8;
    localparam logic [FLOOR_W-1:0] FLOOR_DXT   = 5'd16;
    localparam logic [FLOOR_W-1:0] FLOOR_OTHER = 5'd4;

    typedef struct packed {
        logic [FIELD_W-1:0] bytes_remaining;
        logic [FIELD_W-1:0] four_cc;
        logic [FIELD_W-1:0] pixfmt_flags;
        logic [FIELD_W-1:0] pixfmt_size;
        logic [FIELD_W-1:0] mip_levels;
        logic [FIELD_W-1:0] volume_depth;
        logic [FIELD_W-1:0] pitch_or_linear;
        logic [FIELD_W-1:0] image_width;
        logic [FIELD_W-1:0] image_height;
        logic [FIELD_W-1:0] desc_flags;
        logic [FIELD_W-1:0] desc_size;
    } dhsc_hdr_t;

    // checker verdict and loop seed
    typedef struct packed {
        logic               ok;
        logic               compressed;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [FIELD_W-1:0] extra;
        logic [FLOOR_W-1:0] floor_sz;
    } dhsc_init_t;

endpackage

`default_nettype wire

// ----- rtl/dhsc_check.sv -----
// Header field checks and mip loop seed values.
// Depends on dhsc_pkg.
`default_nettype none

module dhsc_check (
    input  var dhsc_pkg::dhsc_hdr_t  hdr,
    output var dhsc_pkg::dhsc_init_t init
);
    import dhsc_pkg::*;

    logic pitch_f;
    logic linear_f;
    logic mips_f;
    logic base_ok;
    logic pol_ok;
    logic opt_ok;

    assign pitch_f  = (hdr.desc_flags & FLG_PITCH) != '0;
    assign linear_f = (hdr.desc_flags & FLG_LINEAR) != '0;
    assign mips_f   = (hdr.desc_flags & FLG_MIPS) != '0;

    assign base_ok = (hdr.bytes_remaining > HDR_BYTES)
                  && (hdr.desc_size == DESC_SIZE)
                  && (hdr.pixfmt_size == PF_SIZE)
                  && ((hdr.desc_flags & FLG_REQUIRED) == FLG_REQUIRED)
                  && (hdr.image_height != '0) && (hdr.image_width != '0)
                  && (hdr.image_height <= DIM_LIMIT) && (hdr.image_width <= DIM_LIMIT);

    // pitch wins over linear size when both are flagged
    always_comb
    begin
        if (pitch_f)
        begin
            pol_ok = (hdr.pitch_or_linear != '0) && (hdr.pitch_or_linear <= DIM_LIMIT);
        end
        else if (linear_f)
        begin
            pol_ok = hdr.pitch_or_linear != '0;
        end
        else
        begin
            pol_ok = 1'b0;
        end
    end

    assign opt_ok = !(((hdr.desc_flags & FLG_DEPTH) != '0) && (hdr.volume_depth == '0))
                 && !(mips_f && (hdr.mip_levels == '0));

    always_comb
    begin
        init.ok         = base_ok && pol_ok && opt_ok;
        init.compressed = !pitch_f;
        init.w          = pitch_f ? hdr.pitch_or_linear[DIM_W-1:0] : hdr.image_width[DIM_W-1:0];
        init.h          = hdr.image_height[DIM_W-1:0];
        init.extra      = mips_f ? (hdr.mip_levels - 32'd1) : '0;
        init.floor_sz   = FLOOR_OTHER;
        if ((hdr.pixfmt_flags & PF_FOURCC) != '0)
        begin
            if (hdr.four_cc == CODE_DXT1)
            begin
                init.floor_sz = FLOOR_DXT1;
            end
            else if (hdr.four_cc[23:0] == CODE_DXT)
            begin
                init.floor_sz = FLOOR_DXT;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dds_header_size_checker_top.sv -----
// Texture header size checker: validates a decoded header, sums mip level sizes.
// Depends on dhsc_pkg, dhsc_check and dds_header_size_checker_top_assert.svh.
//
//   port group   dir   payload                                    accepted when
//   s_*          in    11 x 32-bit header words (352 bits)        s_tvalid & s_tready
//   m_*          out   total_length (tdata), header_valid (tuser)  m_tvalid & m_tready
//
// One word at a time: accept, check, then the mip loop on a shared 21x21
// multiplier (multiply then accumulate per uncompressed level, up to 22 levels)
// or a shift/compare unit (at most 15 compressed levels), one tail add and the
// output.
// Reset clears the sequencer and the output valid; data registers are not reset.
// A held result stalls the sequencer only at its output cycle.
`default_nettype none

module dds_header_size_checker_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output var  logic         s_tready,
    // desc_size, desc_flags, image_height, image_width, pitch_or_linear,
    // volume_depth, mip_levels, pixfmt_size, pixfmt_flags, four_cc, bytes_remaining
    input  wire logic [351:0] s_tdata,
    output var  logic         m_tvalid,
    input  wire logic         m_tready,
    // total_length[41:0], zero pad[47:42]
    output var  logic [47:0]  m_tdata,
    // header_valid
    output var  logic         m_tuser
);
    import dhsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_ACC,
        S_CLOOP,
        S_TAIL,
        S_OUT
    } state_t;

    state_t              state_reg,   state_next;
    dhsc_hdr_t           hdr_reg,     hdr_next;
    logic [DIM_W-1:0]    w_reg,       w_next;
    logic [DIM_W-1:0]    h_reg,       h_next;
    logic [FIELD_W-1:0]  extra_reg,   extra_next;
    logic [FIELD_W-1:0]  level_reg,   level_next;
    logic [LEN_W-1:0]    data_reg,    data_next;
    logic [LEN_W-1:0]    prod_reg,    prod_next;
    logic [FLOOR_W-1:0]  floor_reg,   floor_next;
    logic                comp_reg,    comp_next;
    logic                ok_reg,      ok_next;
    logic                ovalid_reg,  ovalid_next;
    logic                ook_reg,     ook_next;
    logic [LEN_W-1:0]    olen_reg,    olen_next;

    dhsc_init_t          init;
    logic [FIELD_W-1:0]  lvl_q;
    logic [FIELD_W-1:0]  lvl_n;
    logic [LEN_W-1:0]    tail;
    logic [LEN_W-1:0]    prod_c;
    logic                s_acc;

    dhsc_check u_check (
        .hdr  (hdr_reg),
        .init (init)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ook_reg;
    assign m_tdata  = {{(48-LEN_W){1'b0}}, olen_reg};

    assign prod_c = w_reg * h_reg;
    assign lvl_q  = level_reg >> 2;
    assign lvl_n  = (lvl_q < {{(FIELD_W-FLOOR_W){1'b0}}, floor_reg})
                  ? {{(FIELD_W-FLOOR_W){1'b0}}, floor_reg} : lvl_q;

    // remaining settled levels each add the floor
    always_comb
    begin
        case (floor_reg)
            FLOOR_DXT:  tail = {6'd0, extra_reg, 4'd0};
            FLOOR_DXT1: tail = {7'd0, extra_reg, 3'd0};
            default:    tail = {8'd0, extra_reg, 2'd0};
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        hdr_next    = hdr_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        extra_next  = extra_reg;
        level_next  = level_reg;
        data_next   = data_reg;
        prod_next   = prod_reg;
        floor_next  = floor_reg;
        comp_next   = comp_reg;
        ok_next     = ok_reg;
        ook_next    = ook_reg;
        olen_next   = olen_reg;
        ovalid_next = ovalid_reg && !m_tready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    hdr_next   = s_tdata;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ok_next    = init.ok;
                w_next     = init.w;
                h_next     = init.h;
                extra_next = init.extra;
                floor_next = init.floor_sz;
                comp_next  = init.compressed;
                level_next = hdr_reg.pitch_or_linear;
                data_next  = {10'd0, HDR_BYTES}
                           + (init.compressed ? {10'd0, hdr_reg.pitch_or_linear} : '0);
                if (!init.ok)
                begin
                    state_next = S_OUT;
                end
                else if (init.compressed)
                begin
                    state_next = S_CLOOP;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = prod_c;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                data_next = data_reg + ((prod_reg + 42'd3) & ~42'd3);
                if ((extra_reg != '0) && (w_reg != '0) && (h_reg != '0))
                begin
                    w_next     = w_reg >> 1;
                    h_next     = h_reg >> 1;
                    extra_next = extra_reg - 32'd1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_CLOOP:
            begin
                if (extra_reg == '0)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    level_next = lvl_n;
                    data_next  = data_reg + {10'd0, lvl_n};
                    extra_next = extra_reg - 32'd1;
                    if (lvl_n == {{(FIELD_W-FLOOR_W){1'b0}}, floor_reg})
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL:
            begin
                if (comp_reg)
                begin
                    data_next = data_reg + tail;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    ook_next    = ok_reg;
                    olen_next   = ok_reg ? data_reg : '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg   <= hdr_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        extra_reg <= extra_next;
        level_reg <= level_next;
        data_reg  <= data_next;
        prod_reg  <= prod_next;
        floor_reg <= floor_next;
        comp_reg  <= comp_next;
        ok_reg    <= ok_next;
        ook_reg   <= ook_next;
        olen_reg  <= olen_next;
    end

`include "dds_header_size_checker_top_assert.svh"

    `DHSC_ASSERT_NOW(a_bad_hdr_zero_len, m_tvalid && !m_tuser, m_tdata == '0, "invalid word with nonzero length")
    `DHSC_ASSERT_NOW(a_good_hdr_min_len, m_tvalid && m_tuser, m_tdata[LEN_W-1:0] > 42'd128, "valid word with short length")
    `DHSC_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_tready, "input accepted while busy")
    `DHSC_ASSERT_NEXT(a_cloop_count, (state_reg == S_CLOOP) && (extra_reg != '0), extra_reg == $past(extra_reg) - 32'd1, "level count not stepped")

endmodule

`default_nettype wire

// ----- verif/dhsc_length_checker.sv -----
`timescale 1ns / 1ps
// Watches both stream ports of the texture header size checker and predicts
// each verdict and total length. Depends on dhsc_pkg for the header layout.

module dhsc_length_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [351:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [47:0]  m_tdata,
    input  wire logic         m_tuser,
    output int                fail_count,
    output int                outstanding
);
    import dhsc_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [LEN_W-1:0]  length;
    } verdict_t;

    verdict_t verdicts_q[$];
    int       errors = 0;

    function automatic logic [63:0] round_up4(input logic [63:0] v);
        return (v + 64'd3) & ~64'd3;
    endfunction

    function automatic verdict_t predict_header_length(input dhsc_hdr_t hdr);
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] data;
        logic [63:0] level;
        logic [63:0] floor_sz;
        logic [63:0] extra;
        logic [63:0] sum;
        logic        compressed;
        verdict_t    res;
        res = '0;
        level = 64'd0;
        floor_sz = 64'(FLOOR_OTHER);
        if (hdr.bytes_remaining <= HDR_BYTES) return res;
        if (hdr.desc_size != DESC_SIZE) return res;
        if (hdr.pixfmt_size != PF_SIZE) return res;
        if ((hdr.desc_flags & FLG_REQUIRED) != FLG_REQUIRED) return res;
        if (hdr.image_height == 0 || hdr.image_width == 0) return res;
        if (hdr.image_height > DIM_LIMIT || hdr.image_width > DIM_LIMIT) return res;

        w = 64'(hdr.image_width);
        h = 64'(hdr.image_height);
        // pitch wins over linear size when both are flagged
        if ((hdr.desc_flags & FLG_PITCH) != 0)
        begin
            if (hdr.pitch_or_linear == 0 || hdr.pitch_or_linear > DIM_LIMIT) return res;
            w = 64'(hdr.pitch_or_linear);
            data = round_up4(w * h);
            compressed = 1'b0;
        end
        else if ((hdr.desc_flags & FLG_LINEAR) != 0)
        begin
            if (hdr.pitch_or_linear == 0) return res;
            data = 64'(hdr.pitch_or_linear);
            level = data;
            compressed = 1'b1;
        end
        else
        begin
            return res;
        end

        if ((hdr.desc_flags & FLG_DEPTH) != 0 && hdr.volume_depth == 0) return res;
        if ((hdr.desc_flags & FLG_MIPS) != 0 && hdr.mip_levels == 0) return res;

        if ((hdr.pixfmt_flags & PF_FOURCC) != 0)
        begin
            if (hdr.four_cc == CODE_DXT1)
                floor_sz = 64'(FLOOR_DXT1);
            else if (hdr.four_cc[23:0] == CODE_DXT)
                floor_sz = 64'(FLOOR_DXT);
        end

        if ((hdr.desc_flags & FLG_MIPS) != 0)
        begin
            extra = 64'(hdr.mip_levels) - 64'd1;
            if (compressed)
            begin
                while (extra > 0)
                begin
                    level = level / 4;
                    if (level < floor_sz)
                        level = floor_sz;
                    data = data + level;
                    extra = extra - 1;
                    if (level == floor_sz)
                        break;
                end
                // settled tail: every remaining level sits at the floor
                data = data + extra * floor_sz;
            end
            else
            begin
                while (extra > 0 && w != 0 && h != 0)
                begin
                    w = w / 2;
                    h = h / 2;
                    data = data + round_up4(w * h);
                    extra = extra - 1;
                end
            end
        end

        sum = 64'(HDR_BYTES) + data;
        res.ok = 1'b1;
        res.length = sum[LEN_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                verdicts_q.push_back(predict_header_length(dhsc_hdr_t'(s_tdata)));
            if (m_tvalid && m_tready)
            begin
                if (verdicts_q.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual valid %0b length %h",
                             $time, m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    want = verdicts_q.pop_front();
                    if (m_tuser !== want.ok)
                    begin
                        $display("%0t: header_valid mismatch: expected %0b, actual %0b",
                                 $time, want.ok, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== {6'd0, want.length})
                    begin
                        $display("%0t: total_length mismatch: expected %h, actual %h",
                                 $time, {6'd0, want.length}, m_tdata);
                        errors++;
                    end
                end
            end
        end
        fail_count  <= errors;
        outstanding <= verdicts_q.size();
    end

endmodule

// ----- verif/tb_dds_header_size_checker_top.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for dds_header_size_checker_top: directed headers, then
// random ones. Depends on dhsc_pkg and dhsc_length_checker for the checking.

module tb_dds_header_size_checker_top;
    import dhsc_pkg::*;

    localparam int IDLE_PCT     = 16;
    localparam int RANDOM_WORDS = 1550;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 64;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [351:0] s_tdata  = '0;
    logic         m_tready = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [47:0]  m_tdata;
    logic         m_tuser;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    always #5 clk = ~clk;

    dds_header_size_checker_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    dhsc_length_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return DIM_LIMIT;
            1:       return $urandom_range(1, DIM_LIMIT);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    // smallest valid uncompressed header
    function automatic dhsc_hdr_t base_header();
        dhsc_hdr_t hdr;
        hdr = '0;
        hdr.desc_size       = DESC_SIZE;
        hdr.desc_flags      = FLG_REQUIRED | FLG_PITCH;
        hdr.image_height    = 32'd1;
        hdr.image_width     = 32'd1;
        hdr.pitch_or_linear = 32'd1;
        hdr.pixfmt_size     = PF_SIZE;
        hdr.bytes_remaining = HDR_BYTES + 32'd1;
        return hdr;
    endfunction

    // mostly well-formed headers with random content, some broken, some noise
    function automatic dhsc_hdr_t random_header();
        dhsc_hdr_t hdr;
        int        kind;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            for (int k = 0; k < 11; k++)
                hdr[k*32 +: 32] = $urandom;
            return hdr;
        end
        hdr.desc_size    = DESC_SIZE;
        hdr.desc_flags   = FLG_REQUIRED | ($urandom & ~(FLG_PITCH | FLG_LINEAR));
        hdr.image_height = pick_dim();
        hdr.image_width  = pick_dim();
        case ($urandom_range(0, 9))
            0:
            begin
                hdr.desc_flags      = hdr.desc_flags | FLG_PITCH | FLG_LINEAR;
                hdr.pitch_or_linear = pick_dim();
            end
            1, 2, 3, 4:
            begin
                hdr.desc_flags      = hdr.desc_flags | FLG_PITCH;
                hdr.pitch_or_linear = pick_dim();
            end
            default:
            begin
                hdr.desc_flags      = hdr.desc_flags | FLG_LINEAR;
                hdr.pitch_or_linear = ($urandom_range(0, 3) == 0) ? ($urandom | 32'd1)
                                                                   : $urandom_range(1, 70000);
            end
        endcase
        hdr.volume_depth = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 8);
        case ($urandom_range(0, 5))
            0:       hdr.mip_levels = $urandom;
            1:       hdr.mip_levels = 32'hFFFF_FFFF;
            default: hdr.mip_levels = $urandom_range(1, 24);
        endcase
        hdr.pixfmt_size  = PF_SIZE;
        hdr.pixfmt_flags = ($urandom_range(0, 3) != 0) ? ($urandom | PF_FOURCC)
                                                       : ($urandom & ~PF_FOURCC);
        case ($urandom_range(0, 3))
            0:       hdr.four_cc = CODE_DXT1;
            1:       hdr.four_cc = {8'($urandom_range(0, 255)), CODE_DXT};
            2:       hdr.four_cc = {$urandom_range(0, 1) ? 8'h33 : 8'h35, CODE_DXT};
            default: hdr.four_cc = $urandom;
        endcase
        hdr.bytes_remaining = $urandom_range(0, 1) ? $urandom_range(129, 4096)
                                                   : $urandom_range(129, 32'hFFFF_FFFF);
        if (kind >= 75)
        begin
            case ($urandom_range(0, 12))
                0:  hdr.bytes_remaining = $urandom_range(0, 128);
                1:  hdr.desc_size = hdr.desc_size ^ (32'd1 << $urandom_range(0, 31));
                2:  hdr.pixfmt_size = hdr.pixfmt_size ^ (32'd1 << $urandom_range(0, 31));
                3:  hdr.desc_flags = hdr.desc_flags & ~(FLG_REQUIRED & ($urandom | 32'h1000));
                4:  hdr.image_height = 32'd0;
                5:  hdr.image_width = $urandom_range(DIM_LIMIT + 1, 32'hFFFF_FFFF);
                6:  hdr.image_width = 32'd0;
                7:  hdr.image_height = $urandom_range(DIM_LIMIT + 1, 32'hFFFF_FFFF);
                8:
                begin
                    hdr.desc_flags      = hdr.desc_flags | FLG_PITCH;
                    hdr.pitch_or_linear = $urandom_range(0, 1)
                                          ? 32'd0 : $urandom_range(DIM_LIMIT + 1, 32'hFFFF_FFFF);
                end
                9:
                begin
                    hdr.desc_flags      = (hdr.desc_flags & ~FLG_PITCH) | FLG_LINEAR;
                    hdr.pitch_or_linear = 32'd0;
                end
                10: hdr.desc_flags = hdr.desc_flags & ~(FLG_PITCH | FLG_LINEAR);
                11:
                begin
                    hdr.desc_flags   = hdr.desc_flags | FLG_DEPTH;
                    hdr.volume_depth = 32'd0;
                end
                default:
                begin
                    hdr.desc_flags = hdr.desc_flags | FLG_MIPS;
                    hdr.mip_levels = 32'd0;
                end
            endcase
        end
        return hdr;
    endfunction

    // offer one header word, holding it until it is taken
    task automatic send_word(input dhsc_hdr_t hdr);
        while (take_break())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= hdr;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    always @(posedge clk)
        m_tready <= !take_break();

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** dds_header_size_checker_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        dhsc_hdr_t hdr;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int d = 0; d < 25; d++)
        begin
            hdr = base_header();
            case (d)
                1:
                begin
                    hdr.image_height    = DIM_LIMIT;
                    hdr.image_width     = DIM_LIMIT;
                    hdr.pitch_or_linear = DIM_LIMIT;
                    hdr.desc_flags      = hdr.desc_flags | FLG_MIPS;
                    hdr.mip_levels      = 32'hFFFF_FFFF;
                    hdr.bytes_remaining = 32'hFFFF_FFFF;
                end
                2:
                begin
                    hdr.image_height    = DIM_LIMIT;
                    hdr.pitch_or_linear = 32'd3;
                    hdr.desc_flags      = hdr.desc_flags | FLG_MIPS;
                    hdr.mip_levels      = 32'd5;
                end
                3:
                begin
                    hdr.desc_flags      = FLG_REQUIRED | FLG_LINEAR | FLG_MIPS;
                    hdr.pitch_or_linear = 32'hFFFF_FFFF;
                    hdr.mip_levels      = 32'hFFFF_FFFF;
                    hdr.pixfmt_flags    = PF_FOURCC;
                    hdr.four_cc         = CODE_DXT1;
                end
                4:
                begin
                    // starts below the floor
                    hdr.desc_flags      = FLG_REQUIRED | FLG_LINEAR | FLG_MIPS;
                    hdr.mip_levels      = 32'd10;
                    hdr.pixfmt_flags    = PF_FOURCC;
                    hdr.four_cc         = {8'h35, CODE_DXT};
                end
                5:
                begin
                    // code ignored without the four-character flag
                    hdr.desc_flags      = FLG_REQUIRED | FLG_LINEAR | FLG_MIPS;
                    hdr.pitch_or_linear = 32'd4096;
                    hdr.mip_levels      = 32'd12;
                    hdr.four_cc         = CODE_DXT1;
                end
                6:
                begin
                    hdr.desc_flags      = FLG_REQUIRED | FLG_LINEAR | FLG_MIPS;
                    hdr.pitch_or_linear = 32'd100000;
                    hdr.mip_levels      = 32'd30;
                    hdr.pixfmt_flags    = PF_FOURCC;
                    hdr.four_cc         = 32'h4443_4241;
                end
                7:
                begin
                    hdr.desc_flags      = FLG_REQUIRED | FLG_PITCH | FLG_LINEAR | FLG_MIPS;
                    hdr.pitch_or_linear = 32'd7;
                    hdr.image_height    = 32'd3;
                    hdr.mip_levels      = 32'd4;
                end
                8:  hdr.desc_flags = FLG_REQUIRED;
                9:  hdr.pitch_or_linear = 32'd0;
                10: hdr.pitch_or_linear = DIM_LIMIT + 32'd1;
                11:
                begin
                    hdr.desc_flags      = FLG_REQUIRED | FLG_LINEAR;
                    hdr.pitch_or_linear = 32'd0;
                end
                12: hdr.desc_flags = hdr.desc_flags | FLG_DEPTH;
                13:
                begin
                    hdr.desc_flags   = hdr.desc_flags | FLG_DEPTH;
                    hdr.volume_depth = 32'd1;
                end
                14: hdr.desc_flags = hdr.desc_flags | FLG_MIPS;
                15: hdr.mip_levels = 32'd0;
                16: hdr.bytes_remaining = HDR_BYTES;
                17: hdr.desc_size = DESC_SIZE - 32'd1;
                18: hdr.pixfmt_size = PF_SIZE - 32'd1;
                19: hdr.desc_flags = (FLG_REQUIRED & ~32'd1) | FLG_PITCH;
                20: hdr.image_height = 32'd0;
                21: hdr.image_width = DIM_LIMIT + 32'd1;
                22: hdr = '0;
                23: hdr = '1;
                24:
                begin
                    hdr.desc_flags      = FLG_REQUIRED | FLG_LINEAR | FLG_MIPS;
                    hdr.pitch_or_linear = 32'd64;
                    hdr.mip_levels      = 32'd1;
                end
                default: ;
            endcase
            send_word(hdr);
        end

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // long stretch with both sides always ready
            calm <= (i >= 600 && i < 850);
            send_word(random_header());
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("** dds_header_size_checker_top: PASSED **");
        else
            $display("** dds_header_size_checker_top: FAILED **");
        $finish;
    end

endmodule
